FILE: src/allpass_phaser_with_triangle_lfo_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the allpass phaser
// Shared shorthand for the clocked checks in the controller and datapath.
// ---------------------------------------------------------------------------
`ifndef ALLPASS_PHASER_WITH_TRIANGLE_LFO_TOP_ASSERT_SVH
`define ALLPASS_PHASER_WITH_TRIANGLE_LFO_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active
`define APPH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active
`define APPH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/apph_pkg.sv
// ---------------------------------------------------------------------------
// apph_pkg
// Types, register indexes and constants shared by the phaser modules.
// ---------------------------------------------------------------------------
`default_nettype none

package apph_pkg;

    // Stage count default and configuration port widths
    localparam int NUM_STAGES_DEF = 8;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MANUAL_WORD    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWEEP_DEPTH    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_GAIN  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WET_MIX        = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_LEVEL   = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAN_LEFT_GAIN  = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAN_RIGHT_GAIN = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_STEP      = 8'd7;

    // Reset values of the level and pan registers
    localparam logic [11:0] LEVEL_UNITY = 12'd512;
    localparam logic [15:0] GAIN_UNITY  = 16'd8192;

    // Frame item and result item
    typedef struct packed {
        logic signed [23:0] left_in;
        logic signed [23:0] right_in;
    } apph_in_t;

    typedef struct packed {
        logic signed [23:0] left_out;
        logic signed [23:0] right_out;
    } apph_out_t;

    // Configuration register file
    typedef struct packed {
        logic signed [9:0] manual_word;
        logic [15:0]       sweep_depth;
        logic [15:0]       feedback_gain;
        logic [15:0]       wet_mix;
        logic [11:0]       output_level;
        logic [15:0]       pan_left_gain;
        logic [15:0]       pan_right_gain;
        logic [15:0]       rate_step;
    } apph_cfg_t;

    // Controller sequence
    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_DEPTH,
        S_COEF_U,
        S_COEF_N,
        S_MUL_RECIP,
        S_COEF_A,
        S_MUL_FB,
        S_SUM_FB,
        S_STG_DIFF,
        S_STG_MUL,
        S_STG_ACC,
        S_MUL_MIX,
        S_SUM_W,
        S_MUL_LP_L,
        S_MUL_OUT_L,
        S_SAT_L,
        S_MUL_LP_R,
        S_MUL_OUT_R,
        S_SAT_R,
        S_PUSH
    } apph_state_t;

    // Datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_MUL_DEPTH,
        OP_COEF_U,
        OP_COEF_N,
        OP_MUL_RECIP,
        OP_COEF_A,
        OP_MUL_FB,
        OP_SUM_FB,
        OP_STAGE_DIFF,
        OP_STAGE_MUL,
        OP_STAGE_ACC,
        OP_MUL_MIX,
        OP_SUM_W,
        OP_MUL_LP_L,
        OP_MUL_OUT_L,
        OP_SAT_L,
        OP_MUL_LP_R,
        OP_MUL_OUT_R,
        OP_SAT_R,
        OP_PUSH
    } apph_op_t;

endpackage

`default_nettype wire

FILE: src/apph_ctrl.sv
// ---------------------------------------------------------------------------
// apph_ctrl
// Sequencer for one frame: one datapath command per cycle except while it waits
// in idle or push; walks the allpass stages, owns both channels' handshake flags.
// ---------------------------------------------------------------------------
`default_nettype none

`include "allpass_phaser_with_triangle_lfo_top_assert.svh"

module apph_ctrl #(
    parameter int  NUM_STAGES = apph_pkg::NUM_STAGES_DEF,
    localparam int STAGE_W    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    frame_valid,
    output logic                   frame_ready,
    output logic                   result_valid,
    input  wire                    result_ready,
    output apph_pkg::apph_op_t     cmd_op,
    output logic [STAGE_W-1:0]     stage_idx
);

    apph_pkg::apph_state_t state_reg, state_next;
    logic [STAGE_W-1:0]    stage_reg, stage_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  last_stage;

    // State, stage counter and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apph_pkg::S_IDLE;
            stage_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign last_stage = (stage_reg == STAGE_W'(NUM_STAGES - 1));

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        out_valid_next = out_valid_reg;
        cmd_op         = apph_pkg::OP_NONE;
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            apph_pkg::S_IDLE:
            begin
                if (frame_valid)
                begin
                    cmd_op     = apph_pkg::OP_LOAD_IN;
                    state_next = apph_pkg::S_MUL_DEPTH;
                end
            end
            apph_pkg::S_MUL_DEPTH:
            begin
                cmd_op     = apph_pkg::OP_MUL_DEPTH;
                state_next = apph_pkg::S_COEF_U;
            end
            apph_pkg::S_COEF_U:
            begin
                cmd_op     = apph_pkg::OP_COEF_U;
                state_next = apph_pkg::S_COEF_N;
            end
            apph_pkg::S_COEF_N:
            begin
                cmd_op     = apph_pkg::OP_COEF_N;
                state_next = apph_pkg::S_MUL_RECIP;
            end
            apph_pkg::S_MUL_RECIP:
            begin
                cmd_op     = apph_pkg::OP_MUL_RECIP;
                state_next = apph_pkg::S_COEF_A;
            end
            apph_pkg::S_COEF_A:
            begin
                cmd_op     = apph_pkg::OP_COEF_A;
                state_next = apph_pkg::S_MUL_FB;
            end
            apph_pkg::S_MUL_FB:
            begin
                cmd_op     = apph_pkg::OP_MUL_FB;
                state_next = apph_pkg::S_SUM_FB;
            end
            apph_pkg::S_SUM_FB:
            begin
                cmd_op     = apph_pkg::OP_SUM_FB;
                stage_next = '0;
                state_next = apph_pkg::S_STG_DIFF;
            end
            apph_pkg::S_STG_DIFF:
            begin
                cmd_op     = apph_pkg::OP_STAGE_DIFF;
                state_next = apph_pkg::S_STG_MUL;
            end
            apph_pkg::S_STG_MUL:
            begin
                cmd_op     = apph_pkg::OP_STAGE_MUL;
                state_next = apph_pkg::S_STG_ACC;
            end
            apph_pkg::S_STG_ACC:
            begin
                cmd_op = apph_pkg::OP_STAGE_ACC;
                if (last_stage)
                begin
                    state_next = apph_pkg::S_MUL_MIX;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    state_next = apph_pkg::S_STG_DIFF;
                end
            end
            apph_pkg::S_MUL_MIX:
            begin
                cmd_op     = apph_pkg::OP_MUL_MIX;
                state_next = apph_pkg::S_SUM_W;
            end
            apph_pkg::S_SUM_W:
            begin
                cmd_op     = apph_pkg::OP_SUM_W;
                state_next = apph_pkg::S_MUL_LP_L;
            end
            apph_pkg::S_MUL_LP_L:
            begin
                cmd_op     = apph_pkg::OP_MUL_LP_L;
                state_next = apph_pkg::S_MUL_OUT_L;
            end
            apph_pkg::S_MUL_OUT_L:
            begin
                cmd_op     = apph_pkg::OP_MUL_OUT_L;
                state_next = apph_pkg::S_SAT_L;
            end
            apph_pkg::S_SAT_L:
            begin
                cmd_op     = apph_pkg::OP_SAT_L;
                state_next = apph_pkg::S_MUL_LP_R;
            end
            apph_pkg::S_MUL_LP_R:
            begin
                cmd_op     = apph_pkg::OP_MUL_LP_R;
                state_next = apph_pkg::S_MUL_OUT_R;
            end
            apph_pkg::S_MUL_OUT_R:
            begin
                cmd_op     = apph_pkg::OP_MUL_OUT_R;
                state_next = apph_pkg::S_SAT_R;
            end
            apph_pkg::S_SAT_R:
            begin
                cmd_op     = apph_pkg::OP_SAT_R;
                state_next = apph_pkg::S_PUSH;
            end
            apph_pkg::S_PUSH:
            begin
                // wait here only while the previous result is still held
                if (!out_valid_reg || result_ready)
                begin
                    cmd_op         = apph_pkg::OP_PUSH;
                    out_valid_next = 1'b1;
                    state_next     = apph_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = apph_pkg::S_IDLE;
            end
        endcase
    end

    assign frame_ready  = (state_reg == apph_pkg::S_IDLE);
    assign result_valid = out_valid_reg;
    assign stage_idx    = stage_reg;

    // Checks
    `APPH_ASSERT_NXT(a_busy_after_accept, clk, rst_n, frame_valid && frame_ready, !frame_ready, "frame taken while busy")
    `APPH_ASSERT_IMP(a_push_slot_free, clk, rst_n, cmd_op == apph_pkg::OP_PUSH, !result_valid || result_ready, "result overwritten")
    `APPH_ASSERT_NXT(a_push_shows_valid, clk, rst_n, cmd_op == apph_pkg::OP_PUSH, result_valid, "pushed result not shown")
    `APPH_ASSERT_IMP(a_stage_in_range, clk, rst_n, 1'b1, stage_reg <= STAGE_W'(NUM_STAGES - 1), "stage index out of range")

endmodule

`default_nettype wire

FILE: src/apph_datapath.sv
// ---------------------------------------------------------------------------
// apph_datapath
// One shared multiplier with operand selection, the coefficient, stage and
// output arithmetic, the LFO phase and the allpass history registers.
// ---------------------------------------------------------------------------
`default_nettype none

`include "allpass_phaser_with_triangle_lfo_top_assert.svh"

module apph_datapath #(
    parameter int  NUM_STAGES = apph_pkg::NUM_STAGES_DEF,
    localparam int STAGE_W    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire apph_pkg::apph_cfg_t    cfg,
    input  wire apph_pkg::apph_op_t     cmd_op,
    input  wire [STAGE_W-1:0]           stage_idx,
    input  wire apph_pkg::apph_in_t     frame,
    output apph_pkg::apph_out_t         result
);

    // ceil(2^21 / 5): exact floor division by five for 19-bit values
    localparam logic [19:0] RECIP_FIVE = 20'd419431;
    localparam int          RECIP_SH   = 21;

    // LFO and history state
    logic [23:0]        phase_reg;
    logic signed [31:0] in_hist_reg  [NUM_STAGES];
    logic signed [31:0] out_hist_reg [NUM_STAGES];
    logic signed [31:0] fb_sample_reg;

    // Working registers
    logic signed [24:0] x_reg;
    logic [24:0]        tri_reg;
    logic signed [62:0] prod_reg;
    logic signed [25:0] u_reg;
    logic [18:0]        n_reg;
    logic signed [15:0] a_reg;
    logic signed [32:0] d_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] w_reg;
    logic signed [23:0] ol_reg;
    logic signed [23:0] or_reg;
    apph_pkg::apph_out_t result_reg;

    // Combinational values
    logic signed [25:0] tri_fold;
    logic signed [25:0] tri_abs;
    logic [24:0]        tri_next;
    logic signed [33:0] op_a;
    logic signed [28:0] op_b;
    logic signed [62:0] mul_full;
    logic signed [29:0] manual_term;
    logic signed [29:0] u_raw;
    logic signed [25:0] u_next;
    logic signed [30:0] n_acc;
    logic signed [30:0] n_sum;
    logic [18:0]        n_next;
    logic signed [16:0] a_wide;
    logic signed [15:0] a_next;
    logic signed [31:0] y_next;
    logic signed [47:0] gain_term;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < -48'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
        if (v > 40'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        else if (v < -40'sd8388608)
        begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    // Triangle from the current phase: 2^24 - |2*phase - 2^24|
    always_comb
    begin
        tri_fold = $signed({1'b0, phase_reg, 1'b0}) - 26'sd16777216;
        tri_abs  = tri_fold[25] ? -tri_fold : tri_fold;
        tri_next = 25'd16777216 - tri_abs[24:0];
    end

    // Shared multiplier operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd_op)
            apph_pkg::OP_MUL_DEPTH:
            begin
                op_a = 34'(tri_reg);
                op_b = 29'(cfg.sweep_depth);
            end
            apph_pkg::OP_MUL_RECIP:
            begin
                op_a = 34'(n_reg);
                op_b = 29'(RECIP_FIVE);
            end
            apph_pkg::OP_MUL_FB:
            begin
                op_a = 34'(fb_sample_reg);
                op_b = 29'(cfg.feedback_gain);
            end
            apph_pkg::OP_STAGE_MUL:
            begin
                op_a = 34'(d_reg);
                op_b = 29'(a_reg);
            end
            apph_pkg::OP_MUL_MIX:
            begin
                op_a = 34'(v_reg);
                op_b = 29'(cfg.wet_mix);
            end
            apph_pkg::OP_MUL_LP_L:
            begin
                op_a = 34'(cfg.output_level);
                op_b = 29'(cfg.pan_left_gain);
            end
            apph_pkg::OP_MUL_LP_R:
            begin
                op_a = 34'(cfg.output_level);
                op_b = 29'(cfg.pan_right_gain);
            end
            apph_pkg::OP_MUL_OUT_L, apph_pkg::OP_MUL_OUT_R:
            begin
                // level times pan is left in the product register
                op_a = 34'(w_reg);
                op_b = $signed({1'b0, prod_reg[27:0]});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_full = op_a * op_b;

    // Coefficient: u = -manual - depth*tri, clamped to +-1.0 in Q.24
    always_comb
    begin
        manual_term = -(30'($signed({cfg.manual_word, 15'b0})));
        u_raw       = manual_term - $signed({2'b00, prod_reg[40:13]});
        if (u_raw > 30'sd16777216)
        begin
            u_next = 26'sd16777216;
        end
        else if (u_raw < -30'sd16777216)
        begin
            u_next = -26'sd16777216;
        end
        else
        begin
            u_next = u_raw[25:0];
        end
    end

    // 0.9*u in Q1.15, rounded: floor((9u + 2560) / 1024 / 5), offset to stay positive
    always_comb
    begin
        n_acc  = (31'(u_reg) <<< 3) + 31'(u_reg) + 31'sd2560;
        n_sum  = (n_acc >>> 10) + 31'sd163840;
        n_next = n_sum[18:0];
        a_wide = $signed({1'b0, prod_reg[RECIP_SH+15:RECIP_SH]}) - 17'sd32768;
        a_next = a_wide[15:0];
    end

    // Allpass stage output and the Q3.13 gain term shared by the two sums
    assign y_next    = sat32(48'(in_hist_reg[stage_idx]) + $signed(prod_reg[62:15]));
    assign gain_term = $signed(prod_reg[60:13]);

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd_op)
            apph_pkg::OP_LOAD_IN:
            begin
                // half-weight mono sum in Q8.24 is just L + R
                x_reg   <= 25'(frame.left_in) + 25'(frame.right_in);
                tri_reg <= tri_next;
            end
            apph_pkg::OP_MUL_DEPTH, apph_pkg::OP_MUL_RECIP, apph_pkg::OP_MUL_FB,
            apph_pkg::OP_STAGE_MUL, apph_pkg::OP_MUL_MIX, apph_pkg::OP_MUL_LP_L,
            apph_pkg::OP_MUL_OUT_L, apph_pkg::OP_MUL_LP_R, apph_pkg::OP_MUL_OUT_R:
            begin
                prod_reg <= mul_full;
            end
            apph_pkg::OP_COEF_U:
            begin
                u_reg <= u_next;
            end
            apph_pkg::OP_COEF_N:
            begin
                n_reg <= n_next;
            end
            apph_pkg::OP_COEF_A:
            begin
                a_reg <= a_next;
            end
            apph_pkg::OP_SUM_FB:
            begin
                v_reg <= sat32(48'(x_reg) + gain_term);
            end
            apph_pkg::OP_STAGE_DIFF:
            begin
                d_reg <= 33'(v_reg) - 33'(out_hist_reg[stage_idx]);
            end
            apph_pkg::OP_STAGE_ACC:
            begin
                v_reg <= y_next;
            end
            apph_pkg::OP_SUM_W:
            begin
                w_reg <= sat32(48'(x_reg) + gain_term);
            end
            apph_pkg::OP_SAT_L:
            begin
                ol_reg <= sat24($signed(prod_reg[62:23]));
            end
            apph_pkg::OP_SAT_R:
            begin
                or_reg <= sat24($signed(prod_reg[62:23]));
            end
            apph_pkg::OP_PUSH:
            begin
                result_reg.left_out  <= ol_reg;
                result_reg.right_out <= or_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Phase, histories and feedback sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            fb_sample_reg <= '0;
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd_op)
                apph_pkg::OP_LOAD_IN:
                begin
                    phase_reg <= phase_reg + 24'(cfg.rate_step);
                end
                apph_pkg::OP_STAGE_ACC:
                begin
                    in_hist_reg[stage_idx]  <= v_reg;
                    out_hist_reg[stage_idx] <= y_next;
                end
                apph_pkg::OP_SUM_W:
                begin
                    fb_sample_reg <= v_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result = result_reg;

    // Checks
    `APPH_ASSERT_NXT(a_coef_range, clk, rst_n, cmd_op == apph_pkg::OP_COEF_A, (a_reg <= 16'sd29491) && (a_reg >= -16'sd29491), "coefficient beyond 0.9")
    `APPH_ASSERT_NXT(a_phase_step, clk, rst_n, cmd_op == apph_pkg::OP_LOAD_IN, phase_reg == 24'($past(phase_reg) + 24'($past(cfg.rate_step))), "phase did not advance by rate")
    `APPH_ASSERT_NXT(a_stage_write, clk, rst_n, cmd_op == apph_pkg::OP_STAGE_ACC, out_hist_reg[$past(stage_idx)] == v_reg, "stage history and running value differ")

endmodule

`default_nettype wire

FILE: src/allpass_phaser_with_triangle_lfo_top.sv
// ---------------------------------------------------------------------------
// allpass_phaser_with_triangle_lfo_top
// Stereo-in, stereo-out phaser: mono allpass cascade swept by a triangle LFO.
// ---------------------------------------------------------------------------
// A frame item is accepted only in the idle state, and its result is loaded into
// the output register at the end of the sequence. All multiplications share one
// 34x29 multiplier; each allpass stage runs a difference, a product and an
// accumulate step, and only the product step uses it. A new frame is taken as
// soon as the previous one has been moved to the output register, so a finished
// result can wait for the consumer while the next frame is worked on; if the
// output register is still full at the end, the block holds until it is taken.
// Configuration writes are taken every cycle and must only be made while the
// block is idle. Results are saturated to 24 bits.
`default_nettype none

module allpass_phaser_with_triangle_lfo_top #(
    parameter int  NUM_STAGES = apph_pkg::NUM_STAGES_DEF,
    localparam int STAGE_W    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 frame_valid,
    output logic                                frame_ready,
    input  wire apph_pkg::apph_in_t             frame,
    output logic                                result_valid,
    input  wire                                 result_ready,
    output apph_pkg::apph_out_t                 result,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [apph_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [apph_pkg::CFG_DATA_W-1:0]      cfg_data
);

    apph_pkg::apph_cfg_t cfg_reg, cfg_next;
    apph_pkg::apph_op_t  cmd_op;
    logic [STAGE_W-1:0]  stage_idx;

    // Configuration register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                apph_pkg::CFG_MANUAL_WORD:    cfg_next.manual_word    = cfg_data[9:0];
                apph_pkg::CFG_SWEEP_DEPTH:    cfg_next.sweep_depth    = cfg_data;
                apph_pkg::CFG_FEEDBACK_GAIN:  cfg_next.feedback_gain  = cfg_data;
                apph_pkg::CFG_WET_MIX:        cfg_next.wet_mix        = cfg_data;
                apph_pkg::CFG_OUTPUT_LEVEL:   cfg_next.output_level   = cfg_data[11:0];
                apph_pkg::CFG_PAN_LEFT_GAIN:  cfg_next.pan_left_gain  = cfg_data;
                apph_pkg::CFG_PAN_RIGHT_GAIN: cfg_next.pan_right_gain = cfg_data;
                apph_pkg::CFG_RATE_STEP:      cfg_next.rate_step      = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.manual_word    <= '0;
            cfg_reg.sweep_depth    <= '0;
            cfg_reg.feedback_gain  <= '0;
            cfg_reg.wet_mix        <= '0;
            cfg_reg.output_level   <= apph_pkg::LEVEL_UNITY;
            cfg_reg.pan_left_gain  <= apph_pkg::GAIN_UNITY;
            cfg_reg.pan_right_gain <= apph_pkg::GAIN_UNITY;
            cfg_reg.rate_step      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;

    // Sequencer
    apph_ctrl #(
        .NUM_STAGES (NUM_STAGES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd_op       (cmd_op),
        .stage_idx    (stage_idx)
    );

    // Arithmetic and state
    apph_datapath #(
        .NUM_STAGES (NUM_STAGES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_op    (cmd_op),
        .stage_idx (stage_idx),
        .frame     (frame),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: tb/sv/allpass_phaser_with_triangle_lfo_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// allpass_phaser_with_triangle_lfo_top_tb
// Self-checking bench for the triangle-swept allpass phaser. A short table of
// frames and register writes runs first, then randomly configured sections
// of random frames. Each result is checked against a table value or an in-bench
// fixed-point predictor, with random stalls on both handshakes.
// ---------------------------------------------------------------------------

module allpass_phaser_with_triangle_lfo_top_tb;

    localparam int     NUM_STAGES         = apph_pkg::NUM_STAGES_DEF;
    localparam int     SAMPLE_MAX         = 8388607;
    localparam int     SAMPLE_MIN         = -8388608;
    localparam longint ONE_Q24            = 64'sd16777216;
    localparam longint WORD_MAX           = 64'sd2147483647;
    localparam longint WORD_MIN           = -64'sd2147483648;
    localparam logic [apph_pkg::CFG_INDEX_W-1:0] CFG_NO_REGISTER =
        apph_pkg::CFG_RATE_STEP + 8'd1;
    localparam logic [apph_pkg::CFG_INDEX_W-1:0] CFG_TOP_INDEX   = '1;
    localparam int     RAND_SECTIONS      = 8;
    localparam int     FRAMES_PER_SECTION = 216;
    localparam int     LONG_HOLD_CYCLES   = 300;
    localparam int     DRAIN_CYCLES       = 60;
    localparam int     CYCLE_LIMIT        = 500000;

    typedef enum logic [1:0] {ROW_FIXED, ROW_PREDICTED, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [apph_pkg::CFG_INDEX_W-1:0]   index;
        logic [apph_pkg::CFG_DATA_W-1:0]    data;
        apph_pkg::apph_in_t                 frame;
        apph_pkg::apph_out_t                want;
    } script_row_t;

    // DUT ports
    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              frame_valid  = 1'b0;
    logic                              frame_ready;
    apph_pkg::apph_in_t                frame        = '0;
    logic                              result_valid;
    logic                              result_ready = 1'b0;
    apph_pkg::apph_out_t               result;
    logic                              cfg_valid    = 1'b0;
    logic                              cfg_ready;
    logic [apph_pkg::CFG_INDEX_W-1:0]  cfg_index    = '0;
    logic [apph_pkg::CFG_DATA_W-1:0]   cfg_data     = '0;

    // Predictor state and register shadow
    apph_pkg::apph_cfg_t   shadow_cfg;
    logic [23:0]           lfo_acc;
    int                    stage_x [NUM_STAGES];
    int                    stage_y [NUM_STAGES];
    int                    loop_sample;
    apph_pkg::apph_out_t   expected_out [$];
    script_row_t           directed_rows [$];

    // Idling control shared by sender and receiver
    bit                    quiet         = 1'b0;
    bit                    hold_request  = 1'b0;
    int                    sender_idle   = 2;
    int                    receiver_idle = 2;
    int                    fail_count    = 0;
    apph_pkg::apph_out_t   want_out;

    allpass_phaser_with_triangle_lfo_top #(
        .NUM_STAGES(NUM_STAGES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .frame_valid(frame_valid),
        .frame_ready(frame_ready),
        .frame(frame),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint clamp(longint value, longint lo, longint hi);
        return (value < lo) ? lo : ((value > hi) ? hi : value);
    endfunction

    // One frame through the phaser: coefficient, LFO step, feedback, cascade, mix
    function automatic apph_pkg::apph_out_t phaser_output(apph_pkg::apph_in_t f);
        longint fold, tri_val, u, a, x, v, d, y, w, l, r;
        apph_pkg::apph_out_t res;
        int s;
        // triangle from the current phase, then the clamped sweep term
        fold = 2 * longint'(lfo_acc) - ONE_Q24;
        tri_val = ONE_Q24 - ((fold < 0) ? -fold : fold);
        u = -longint'($signed(shadow_cfg.manual_word)) * 32768
            - ((longint'(shadow_cfg.sweep_depth) * tri_val) >>> 13);
        u = clamp(u, -ONE_Q24, ONE_Q24);
        // 0.9 * u in Q1.15, half up; the offset keeps the division positive
        a = (u * 9 + 2560 + 64'sd5120 * 32768) / 5120 - 32768;
        lfo_acc = lfo_acc + shadow_cfg.rate_step;

        x = longint'($signed(f.left_in)) + longint'($signed(f.right_in));
        v = clamp(x + ((longint'(shadow_cfg.feedback_gain) * longint'(loop_sample)) >>> 13),
                  WORD_MIN, WORD_MAX);
        for (s = 0; s < NUM_STAGES; s++)
        begin
            d = v - longint'(stage_y[s]);
            y = clamp(((a * d) >>> 15) + longint'(stage_x[s]), WORD_MIN, WORD_MAX);
            stage_x[s] = int'(v);
            stage_y[s] = int'(y);
            v = y;
        end
        loop_sample = int'(v);

        // dry plus wet, then level and pan per side
        w = clamp(x + ((longint'(shadow_cfg.wet_mix) * v) >>> 13), WORD_MIN, WORD_MAX);
        l = clamp((w * longint'(shadow_cfg.output_level)
                   * longint'(shadow_cfg.pan_left_gain)) >>> 23, SAMPLE_MIN, SAMPLE_MAX);
        r = clamp((w * longint'(shadow_cfg.output_level)
                   * longint'(shadow_cfg.pan_right_gain)) >>> 23, SAMPLE_MIN, SAMPLE_MAX);
        res.left_out  = l[23:0];
        res.right_out = r[23:0];
        return res;
    endfunction

    // Table builders
    function automatic void add_fixed(int l, int r, int wl, int wr);
        script_row_t row;
        row = '0;
        row.kind = ROW_FIXED;
        row.frame.left_in = l[23:0];
        row.frame.right_in = r[23:0];
        row.want.left_out = wl[23:0];
        row.want.right_out = wr[23:0];
        directed_rows.push_back(row);
    endfunction

    function automatic void add_frame(int l, int r);
        script_row_t row;
        row = '0;
        row.kind = ROW_PREDICTED;
        row.frame.left_in = l[23:0];
        row.frame.right_in = r[23:0];
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg(logic [apph_pkg::CFG_INDEX_W-1:0] index,
                                    logic [apph_pkg::CFG_DATA_W-1:0] data);
        script_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.index = index;
        row.data = data;
        directed_rows.push_back(row);
    endfunction

    // Random samples, biased toward the rails and small values
    function automatic logic [23:0] random_sample();
        logic [23:0] value;
        case ($urandom_range(0, 9))
            0:       value = 24'(SAMPLE_MAX);
            1:       value = 24'(SAMPLE_MIN);
            2, 3:    value = 24'($urandom_range(0, 8191) - 4096);
            default: value = 24'($urandom);
        endcase
        return value;
    endfunction

    function automatic apph_pkg::apph_in_t random_frame();
        apph_pkg::apph_in_t f;
        f.left_in = random_sample();
        f.right_in = ($urandom_range(0, 7) == 0) ? f.left_in : random_sample();
        return f;
    endfunction

    function automatic logic [apph_pkg::CFG_DATA_W-1:0] pick_word(
        logic [apph_pkg::CFG_DATA_W-1:0] hi,
        logic [apph_pkg::CFG_DATA_W-1:0] lo);
        logic [apph_pkg::CFG_DATA_W-1:0] value;
        case ($urandom_range(0, 3))
            0:       value = lo;
            1:       value = hi;
            default: value = apph_pkg::CFG_DATA_W'($urandom);
        endcase
        return value;
    endfunction

    // Offer one frame item; the next call or the caller decides whether valid drops
    task automatic send_frame(apph_pkg::apph_in_t f, bit fixed,
                              apph_pkg::apph_out_t fixed_out);
        int gap;
        apph_pkg::apph_out_t predicted;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) < sender_idle)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame <= f;
        do
            @(posedge clk);
        while (!frame_ready);
        predicted = phaser_output(f);
        expected_out.push_back(fixed ? fixed_out : predicted);
    endtask

    // Register write; valid stays up for a following write
    task automatic write_reg(logic [apph_pkg::CFG_INDEX_W-1:0] index,
                             logic [apph_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            apph_pkg::CFG_MANUAL_WORD:    shadow_cfg.manual_word    = data[9:0];
            apph_pkg::CFG_SWEEP_DEPTH:    shadow_cfg.sweep_depth    = data;
            apph_pkg::CFG_FEEDBACK_GAIN:  shadow_cfg.feedback_gain  = data;
            apph_pkg::CFG_WET_MIX:        shadow_cfg.wet_mix        = data;
            apph_pkg::CFG_OUTPUT_LEVEL:   shadow_cfg.output_level   = data[11:0];
            apph_pkg::CFG_PAN_LEFT_GAIN:  shadow_cfg.pan_left_gain  = data;
            apph_pkg::CFG_PAN_RIGHT_GAIN: shadow_cfg.pan_right_gain = data;
            apph_pkg::CFG_RATE_STEP:      shadow_cfg.rate_step      = data;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        while (expected_out.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure_random();
        write_reg(apph_pkg::CFG_MANUAL_WORD, pick_word(16'h01FF, 16'h0200));
        write_reg(apph_pkg::CFG_SWEEP_DEPTH, pick_word(16'hFFFF, 16'h0000));
        // mostly moderate feedback so the cascade does not just sit on the rails
        write_reg(apph_pkg::CFG_FEEDBACK_GAIN,
                  $urandom_range(0, 1) ? pick_word(16'hFFFF, 16'h0000)
                                       : 16'($urandom_range(0, 8191)));
        write_reg(apph_pkg::CFG_WET_MIX, pick_word(16'hFFFF, 16'h0000));
        write_reg(apph_pkg::CFG_OUTPUT_LEVEL, pick_word(16'h0FFF, 16'h0000));
        write_reg(apph_pkg::CFG_PAN_LEFT_GAIN, pick_word(16'hFFFF, 16'h0000));
        write_reg(apph_pkg::CFG_PAN_RIGHT_GAIN, pick_word(16'hFFFF, 16'h0000));
        write_reg(apph_pkg::CFG_RATE_STEP, pick_word(16'hFFFF, 16'h0000));
        write_reg(apph_pkg::CFG_INDEX_W'($urandom_range(CFG_NO_REGISTER, CFG_TOP_INDEX)),
                  apph_pkg::CFG_DATA_W'($urandom));
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_out.size() == 0)
            begin
                $error("unexpected result item: left_out %0d, right_out %0d",
                       result.left_out, result.right_out);
                fail_count++;
            end
            else
            begin
                want_out = expected_out.pop_front();
                if (result.left_out !== want_out.left_out)
                begin
                    $error("left_out: expected %0d, actual %0d",
                           want_out.left_out, result.left_out);
                    fail_count++;
                end
                if (result.right_out !== want_out.right_out)
                begin
                    $error("right_out: expected %0d, actual %0d",
                           want_out.right_out, result.right_out);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial
    begin
        int stall;
        int long_hold;
        stall = 0;
        long_hold = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                long_hold--;
                result_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                long_hold = LONG_HOLD_CYCLES - 1;
                result_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                result_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 31) < receiver_idle)
            begin
                stall = $urandom_range(1, 13) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus
    initial
    begin
        script_row_t row;
        int section;
        int n;

        // predictor matches the block after reset
        shadow_cfg = '0;
        shadow_cfg.output_level = apph_pkg::LEVEL_UNITY;
        shadow_cfg.pan_left_gain = apph_pkg::GAIN_UNITY;
        shadow_cfg.pan_right_gain = apph_pkg::GAIN_UNITY;
        lfo_acc = '0;
        loop_sample = 0;
        foreach (stage_x[s])
        begin
            stage_x[s] = 0;
            stage_y[s] = 0;
        end

        // reset settings: zero coefficient, no wet, output is floor((L+R)/2)
        add_fixed(0, 0, 0, 0);
        add_fixed(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        add_fixed(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        add_fixed(SAMPLE_MAX, SAMPLE_MIN, -1, -1);
        add_fixed(-3, 0, -2, -2);
        // left muted; junk above the level field is dropped
        add_reg(apph_pkg::CFG_PAN_LEFT_GAIN, 16'h0000);
        add_reg(apph_pkg::CFG_OUTPUT_LEVEL, 16'hF200);
        add_fixed(100, 100, 0, 100);
        add_fixed(-100, -101, 0, -101);
        // full right gain and level saturate the output
        add_reg(apph_pkg::CFG_PAN_RIGHT_GAIN, 16'hFFFF);
        add_reg(apph_pkg::CFG_OUTPUT_LEVEL, 16'h0FFF);
        add_fixed(SAMPLE_MAX, SAMPLE_MAX, 0, SAMPLE_MAX);
        add_fixed(SAMPLE_MIN, SAMPLE_MIN, 0, SAMPLE_MIN);
        add_fixed(0, 0, 0, 0);
        // full sweep toward the negative clamp, fast LFO, full wet
        add_reg(apph_pkg::CFG_PAN_LEFT_GAIN, apph_pkg::GAIN_UNITY);
        add_reg(apph_pkg::CFG_PAN_RIGHT_GAIN, apph_pkg::GAIN_UNITY);
        add_reg(apph_pkg::CFG_OUTPUT_LEVEL, {4'hF, apph_pkg::LEVEL_UNITY});
        add_reg(apph_pkg::CFG_MANUAL_WORD, 16'hFDFF);
        add_reg(apph_pkg::CFG_SWEEP_DEPTH, 16'hFFFF);
        add_reg(apph_pkg::CFG_FEEDBACK_GAIN, 16'd6000);
        add_reg(apph_pkg::CFG_WET_MIX, 16'hFFFF);
        add_reg(apph_pkg::CFG_RATE_STEP, 16'hFFFF);
        add_reg(CFG_NO_REGISTER, 16'hFFFF);
        add_reg(CFG_TOP_INDEX, 16'hFFFF);
        add_frame(SAMPLE_MAX, SAMPLE_MAX);
        add_frame(SAMPLE_MIN, SAMPLE_MIN);
        add_frame(SAMPLE_MAX, SAMPLE_MIN);
        add_frame(0, 0);
        add_frame(5000, -7000);
        add_frame(SAMPLE_MIN, SAMPLE_MAX);
        add_frame(1, 1);
        // centre at the positive clamp, no sweep, maximum feedback
        add_reg(apph_pkg::CFG_MANUAL_WORD, 16'h0200);
        add_reg(apph_pkg::CFG_SWEEP_DEPTH, 16'h0000);
        add_reg(apph_pkg::CFG_FEEDBACK_GAIN, 16'hFFFF);
        add_reg(apph_pkg::CFG_RATE_STEP, 16'h0000);
        add_frame(SAMPLE_MAX, SAMPLE_MAX);
        add_frame(SAMPLE_MIN, SAMPLE_MIN);
        add_frame(0, 0);
        add_frame(SAMPLE_MAX, SAMPLE_MAX);
        add_frame(12345, -54321);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                frame_valid <= 1'b0;
                drain_results();
                write_reg(row.index, row.data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_frame(row.frame, row.kind == ROW_FIXED, row.want);
            end
        end

        // random sections, each with its own register setting
        for (section = 0; section < RAND_SECTIONS; section++)
        begin
            frame_valid <= 1'b0;
            drain_results();
            configure_random();
            cfg_valid <= 1'b0;
            quiet = (section == RAND_SECTIONS - 1);
            if (section == 2)
                hold_request = 1'b1;
            for (n = 0; n < FRAMES_PER_SECTION; n++)
            begin
                if (n % 64 == 0)
                begin
                    sender_idle = $urandom_range(0, 4);
                    receiver_idle = $urandom_range(0, 4);
                end
                send_frame(random_frame(), 1'b0, '0);
            end
        end

        frame_valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
